/* hw/rtl/atip_pkg.sv */
// shared types, constants and decode tables of the asset transfer instruction parser
package atip_pkg;

	localparam int MAX_SCRIPT_BYTES = 256;
	localparam int POS_W = $clog2(MAX_SCRIPT_BYTES);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SCRIPT_BYTES - 1);

	localparam int ACC_W = 56;
	localparam int POW_W = 50;
	localparam int HALF_W = ACC_W / 2;
	localparam int AMOUNT_W = 64;
	localparam int PROD_W = 2 * ACC_W;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int CNT_W = FIFO_AW + 1;

	localparam int CFG_IDX_W = 2;

	// header bytes
	localparam logic [7:0] MARKER_OP = 8'h6a;
	localparam logic [7:0] TAG_D = 8'h44;
	localparam logic [7:0] TAG_A = 8'h41;
	localparam logic [7:0] MIN_SCRIPT_LEN = 8'd6;
	localparam logic [8:0] LEN_OVERHEAD = 9'd2;

	localparam logic [POS_W-1:0] POS_MARKER = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(1);
	localparam logic [POS_W-1:0] POS_TAG_D = POS_W'(2);
	localparam logic [POS_W-1:0] POS_TAG_A = POS_W'(3);
	localparam logic [POS_W-1:0] POS_VERSION = POS_W'(4);
	localparam logic [POS_W-1:0] POS_TYPE = POS_W'(5);

	// flags byte
	localparam int FLAG_SKIP = 7;
	localparam int FLAG_RANGE = 6;
	localparam int FLAG_PCT = 5;
	localparam logic [12:0] BURN_INDEX = 13'd31;

	localparam logic [2:0] SIZE_CODE_MAX = 3'd6;
	localparam logic [2:0] SIZE_CODE_BAD = 3'd7;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_FLAGS,
		PH_INDEX,
		PH_AMOUNT0,
		PH_AMOUNTN,
		PH_DEAD
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRANSFER_LOW,
		REG_TRANSFER_HIGH,
		REG_BURN_LOW,
		REG_BURN_HIGH
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] transfer_type_low;
		logic [7:0] transfer_type_high;
		logic [7:0] burn_type_low;
		logic [7:0] burn_type_high;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		transfer_type_low: 8'd16,
		transfer_type_high: 8'd31,
		burn_type_low: 8'd32,
		burn_type_high: 8'd47
	};

	typedef struct packed {
		logic [7:0] script_byte;
		logic [7:0] script_length;
		logic [12:0] target_output;
		logic first_byte;
		logic last_byte;
	} item_t;

	typedef struct packed {
		logic result_kind;
		logic skip_flag;
		logic range_flag;
		logic percent_flag;
		logic [12:0] output_index;
		logic [63:0] amount;
		logic burn_flag;
		logic [7:0] input_index;
		logic asset_sent;
		logic header_valid;
		logic last_result;
	} result_t;

	// which results a stage holds
	typedef struct packed {
		logic instr;
		logic verd;
	} stage_vld_t;

	typedef struct packed {
		logic skip;
		logic range;
		logic pct;
		logic [12:0] idx;
		logic burn;
		logic [7:0] in_idx;
		logic asset_sent;
		logic header_valid;
	} tag_t;

	typedef struct packed {
		tag_t tag;
		logic [ACC_W-1:0] mant;
		logic [POW_W-1:0] pow;
	} pass_t;

	// low exponent bits per size code
	function automatic logic [2:0] exp_bits(input logic [2:0] size);
		logic [2:0] e;
		case (size) inside
			3'd1, 3'd2, 3'd3: e = 3'd4;
			3'd4, 3'd5: e = 3'd3;
			default: e = 3'd0;
		endcase
		return e;
	endfunction

	function automatic logic [3:0] exp_mask(input logic [2:0] size);
		logic [3:0] m;
		case (size) inside
			3'd1, 3'd2, 3'd3: m = 4'hf;
			3'd4, 3'd5: m = 4'h7;
			default: m = 4'h0;
		endcase
		return m;
	endfunction

	// bits of the first amount byte that belong to the value
	function automatic logic [7:0] lead_mask(input logic [2:0] code);
		logic [7:0] m;
		case (code)
			SIZE_CODE_MAX: m = 8'h3f;
			default: m = 8'h1f;
		endcase
		return m;
	endfunction

	function automatic logic [POW_W-1:0] pow10(input logic [3:0] ex);
		logic [POW_W-1:0] p;
		case (ex)
			4'd0: p = 50'd1;
			4'd1: p = 50'd10;
			4'd2: p = 50'd100;
			4'd3: p = 50'd1000;
			4'd4: p = 50'd10000;
			4'd5: p = 50'd100000;
			4'd6: p = 50'd1000000;
			4'd7: p = 50'd10000000;
			4'd8: p = 50'd100000000;
			4'd9: p = 50'd1000000000;
			4'd10: p = 50'd10000000000;
			4'd11: p = 50'd100000000000;
			4'd12: p = 50'd1000000000000;
			4'd13: p = 50'd10000000000000;
			4'd14: p = 50'd100000000000000;
			default: p = 50'd1000000000000000;
		endcase
		return p;
	endfunction

endpackage

/* hw/rtl/atip_parser.sv */
// script byte parser: header checks, instruction fields and amount mantissa/scale
module atip_parser import atip_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input item_t item,
	input cfg_t cfg,
	output stage_vld_t vld,
	output pass_t pass,
	output logic [1:0] nres
);

	logic [POS_W-1:0] pos_q;
	phase_t phase_q;
	logic hdr_ok_q;
	logic [7:0] flags_q;
	logic [12:0] idx_q;
	logic [ACC_W-1:0] acc_q;
	logic [2:0] left_q;
	logic [2:0] size_q;
	logic matched_q;
	logic [7:0] in_cnt_q;

	// state as seen by this byte, after a restart on the first byte
	logic [POS_W-1:0] c_pos;
	phase_t c_phase;
	logic c_hdr;
	logic [7:0] c_flags;
	logic [12:0] c_idx;
	logic [ACC_W-1:0] c_acc;
	logic [2:0] c_left;
	logic [2:0] c_size;
	logic c_matched;
	logic [7:0] c_cnt;

	logic [POS_W-1:0] pos_n;
	phase_t phase_n;
	logic hdr_n;
	logic [7:0] flags_n;
	logic [12:0] idx_n;
	logic [ACC_W-1:0] acc_n;
	logic [2:0] left_n;
	logic [2:0] size_n;
	logic matched_n;
	logic [7:0] cnt_n;

	logic [7:0] b;
	logic [7:0] len;
	logic hdr_fail;
	logic type_ok;
	logic start_ok;
	logic emit;
	logic pct_path;
	logic [2:0] code;
	logic burn;
	logic match_now;
	logic [ACC_W-1:0] dec_mant;
	logic [3:0] dec_ex;

	assign b = item.script_byte;
	assign len = item.script_length;

	assign c_pos = item.first_byte ? '0 : pos_q;
	assign c_phase = item.first_byte ? PH_HEADER : phase_q;
	assign c_hdr = item.first_byte ? 1'b1 : hdr_ok_q;
	assign c_flags = item.first_byte ? '0 : flags_q;
	assign c_idx = item.first_byte ? '0 : idx_q;
	assign c_acc = item.first_byte ? '0 : acc_q;
	assign c_left = item.first_byte ? '0 : left_q;
	assign c_size = item.first_byte ? '0 : size_q;
	assign c_matched = item.first_byte ? 1'b0 : matched_q;
	assign c_cnt = item.first_byte ? '0 : in_cnt_q;

	assign type_ok = (b >= cfg.transfer_type_low && b <= cfg.transfer_type_high) ||
		(b >= cfg.burn_type_low && b <= cfg.burn_type_high);
	assign start_ok = (9'(c_pos) + 9'd1) < {1'b0, len};

	always_comb begin
		case (c_pos)
			POS_MARKER: hdr_fail = (b != MARKER_OP) || (len <= MIN_SCRIPT_LEN);
			POS_LENGTH: hdr_fail = (b == 8'd0) || (({1'b0, b} + LEN_OVERHEAD) > {1'b0, len});
			POS_TAG_D: hdr_fail = (b != TAG_D);
			POS_TAG_A: hdr_fail = (b != TAG_A);
			POS_VERSION: hdr_fail = 1'b0;
			default: hdr_fail = !type_ok;
		endcase
	end

	assign hdr_n = c_hdr && !((c_phase == PH_HEADER) && hdr_fail);
	assign pos_n = (c_pos == POS_MAX) ? c_pos : c_pos + POS_W'(1);
	assign code = (b[7:5] == SIZE_CODE_BAD) ? SIZE_CODE_MAX : b[7:5];

	// next phase
	always_comb begin
		phase_n = c_phase;
		unique case (c_phase)
			PH_HEADER: begin
				if (c_pos >= POS_TYPE)
					phase_n = hdr_n ? PH_FLAGS : PH_DEAD;
			end
			PH_FLAGS: begin
				if (start_ok)
					phase_n = b[FLAG_RANGE] ? PH_INDEX : PH_AMOUNT0;
			end
			PH_INDEX: phase_n = PH_AMOUNT0;
			PH_AMOUNT0: phase_n = emit ? PH_FLAGS : PH_AMOUNTN;
			PH_AMOUNTN: begin
				if (emit)
					phase_n = PH_FLAGS;
			end
			PH_DEAD: phase_n = PH_DEAD;
			default: phase_n = c_phase;
		endcase
	end

	// instruction fields and amount accumulation
	always_comb begin
		flags_n = c_flags;
		idx_n = c_idx;
		acc_n = c_acc;
		left_n = c_left;
		size_n = c_size;
		emit = 1'b0;
		pct_path = 1'b0;
		unique case (c_phase)
			PH_FLAGS: begin
				if (start_ok) begin
					flags_n = b;
					idx_n = {8'd0, b[4:0]};
				end
			end
			PH_INDEX: idx_n = {c_idx[4:0], b};
			PH_AMOUNT0: begin
				if (c_flags[FLAG_PCT]) begin
					emit = 1'b1;
					pct_path = 1'b1;
				end else begin
					size_n = code;
					acc_n = {48'd0, b & lead_mask(code)};
					left_n = code;
					emit = (code == 3'd0);
				end
			end
			PH_AMOUNTN: begin
				acc_n = {c_acc[ACC_W-9:0], b};
				left_n = c_left - 3'd1;
				emit = (left_n == 3'd0);
			end
			default: begin
			end
		endcase
	end

	assign dec_mant = acc_n >> exp_bits(size_n);
	assign dec_ex = acc_n[3:0] & exp_mask(size_n);

	assign burn = (c_idx == BURN_INDEX) && !c_flags[FLAG_RANGE];
	assign match_now = emit && !burn && (c_idx == item.target_output);
	assign matched_n = c_matched || match_now;
	assign cnt_n = (emit && c_flags[FLAG_SKIP]) ? c_cnt + 8'd1 : c_cnt;

	assign vld.instr = emit;
	assign vld.verd = item.last_byte;
	assign nres = {1'b0, emit} + {1'b0, item.last_byte};

	always_comb begin
		pass.tag.skip = c_flags[FLAG_SKIP];
		pass.tag.range = c_flags[FLAG_RANGE];
		pass.tag.pct = c_flags[FLAG_PCT];
		pass.tag.idx = c_idx;
		pass.tag.burn = burn;
		pass.tag.in_idx = c_cnt;
		pass.tag.header_valid = hdr_n && (phase_n != PH_HEADER) && (phase_n != PH_DEAD);
		pass.tag.asset_sent = pass.tag.header_valid && matched_n;
		// a percentage goes through the scaler with a factor of one
		pass.mant = pct_path ? {48'd0, b} : dec_mant;
		pass.pow = pct_path ? POW_W'(1) : pow10(dec_ex);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= PH_HEADER;
			hdr_ok_q <= 1'b1;
			flags_q <= '0;
			idx_q <= '0;
			acc_q <= '0;
			left_q <= '0;
			size_q <= '0;
			matched_q <= 1'b0;
			in_cnt_q <= '0;
		end else if (accept) begin
			if (item.last_byte) begin
				pos_q <= '0;
				phase_q <= PH_HEADER;
				hdr_ok_q <= 1'b1;
				flags_q <= '0;
				idx_q <= '0;
				acc_q <= '0;
				left_q <= '0;
				size_q <= '0;
				matched_q <= 1'b0;
				in_cnt_q <= '0;
			end else begin
				pos_q <= pos_n;
				phase_q <= phase_n;
				hdr_ok_q <= hdr_n;
				flags_q <= flags_n;
				idx_q <= idx_n;
				acc_q <= acc_n;
				left_q <= left_n;
				size_q <= size_n;
				matched_q <= matched_n;
				in_cnt_q <= cnt_n;
			end
		end
	end

endmodule

/* hw/rtl/atip_scale.sv */
// two-stage mantissa times power-of-ten multiplier with saturation
module atip_scale import atip_pkg::*; (
	input logic clk,
	input logic arst_n,
	input stage_vld_t vld_s1,
	input pass_t pass_s1,
	output stage_vld_t vld_s3,
	output tag_t tag_s3,
	output logic [AMOUNT_W-1:0] amount_s3
);

	stage_vld_t vld_s2;
	tag_t tag_s2;
	logic [2*HALF_W-1:0] pp_ll_s2;
	logic [2*HALF_W-1:0] pp_hl_s2;
	logic [HALF_W+POW_W-HALF_W-1:0] pp_lh_s2;
	logic [HALF_W+POW_W-HALF_W-1:0] pp_hh_s2;

	logic [2*HALF_W:0] mid;
	logic [PROD_W-1:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= '0;
			vld_s3 <= '0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// partial products on 28-bit halves
	always_ff @(posedge clk) begin
		tag_s2 <= pass_s1.tag;
		pp_ll_s2 <= pass_s1.mant[HALF_W-1:0] * pass_s1.pow[HALF_W-1:0];
		pp_hl_s2 <= pass_s1.mant[ACC_W-1:HALF_W] * pass_s1.pow[HALF_W-1:0];
		pp_lh_s2 <= pass_s1.mant[HALF_W-1:0] * pass_s1.pow[POW_W-1:HALF_W];
		pp_hh_s2 <= pass_s1.mant[ACC_W-1:HALF_W] * pass_s1.pow[POW_W-1:HALF_W];
	end

	assign mid = {1'b0, pp_hl_s2} + (2*HALF_W+1)'(pp_lh_s2);
	assign prod = (PROD_W'(pp_hh_s2) << (2*HALF_W)) + (PROD_W'(mid) << HALF_W) +
		PROD_W'(pp_ll_s2);

	always_ff @(posedge clk) begin
		tag_s3 <= tag_s2;
		amount_s3 <= (|prod[PROD_W-1:AMOUNT_W]) ? '1 : prod[AMOUNT_W-1:0];
	end

endmodule

/* hw/rtl/asset_transfer_instruction_parser.sv */
// asset transfer instruction parser top level: config registers, pipeline and result queue
//
//  channel  direction  handshake                  payload
//  item     in         item_valid / item_stall    item_t   (one script byte)
//  result   out        result_valid / result_stall result_t (instruction or verdict)
//  cfg      in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one script byte is taken every cycle unless item_stall is high; a byte gives up to two
// results, which leave a 16-entry queue at one per cycle unless result_stall is high
// a byte's parse output, partial products and sum are each registered before the queue
// item_stall rises when the queue plus the results in flight leave no room for two more
// reset restores the type ranges, restarts parsing and empties the queue
// the queue head holds while result_stall is high; cfg_ready is always high
module asset_transfer_instruction_parser import atip_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output logic result_valid,
	input logic result_stall,
	output result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [7:0] cfg_data
);

	cfg_t cfg_q;
	logic item_acc;
	logic pop;

	stage_vld_t p_vld;
	pass_t p_pass;
	logic [1:0] p_nres;

	stage_vld_t vld_s1;
	pass_t pass_s1;
	stage_vld_t vld_s3;
	tag_t tag_s3;
	logic [AMOUNT_W-1:0] amount_s3;

	result_t fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] credit_q;
	logic [CNT_W-1:0] n_push;
	logic [CNT_W-1:0] n_take;
	result_t res_instr;
	result_t res_verd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TRANSFER_LOW: cfg_q.transfer_type_low <= cfg_data;
				REG_TRANSFER_HIGH: cfg_q.transfer_type_high <= cfg_data;
				REG_BURN_LOW: cfg_q.burn_type_low <= cfg_data;
				REG_BURN_HIGH: cfg_q.burn_type_high <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign item_stall = credit_q > CNT_W'(FIFO_DEPTH - 2);
	assign item_acc = item_valid && !item_stall;

	atip_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(item_acc),
		.item(item),
		.cfg(cfg_q),
		.vld(p_vld),
		.pass(p_pass),
		.nres(p_nres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
		end else begin
			vld_s1 <= item_acc ? p_vld : '0;
		end
	end

	always_ff @(posedge clk) begin
		pass_s1 <= p_pass;
	end

	atip_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.vld_s1(vld_s1),
		.pass_s1(pass_s1),
		.vld_s3(vld_s3),
		.tag_s3(tag_s3),
		.amount_s3(amount_s3)
	);

	always_comb begin
		res_instr.result_kind = 1'b0;
		res_instr.skip_flag = tag_s3.skip;
		res_instr.range_flag = tag_s3.range;
		res_instr.percent_flag = tag_s3.pct;
		res_instr.output_index = tag_s3.idx;
		res_instr.amount = amount_s3;
		res_instr.burn_flag = tag_s3.burn;
		res_instr.input_index = tag_s3.in_idx;
		res_instr.asset_sent = 1'b0;
		res_instr.header_valid = 1'b1;
		res_instr.last_result = !vld_s3.verd;

		res_verd = '0;
		res_verd.result_kind = 1'b1;
		res_verd.asset_sent = tag_s3.asset_sent;
		res_verd.header_valid = tag_s3.header_valid;
		res_verd.last_result = 1'b1;
	end

	// an instruction goes ahead of the verdict of the same transaction
	always_ff @(posedge clk) begin
		if (vld_s3.instr)
			fifo_q[wr_ptr_q] <= res_instr;
		if (vld_s3.verd)
			fifo_q[wr_ptr_q + FIFO_AW'(vld_s3.instr)] <= res_verd;
	end

	assign result_valid = fill_q != '0;
	assign result = fifo_q[rd_ptr_q];
	assign pop = result_valid && !result_stall;

	assign n_push = CNT_W'(vld_s3.instr) + CNT_W'(vld_s3.verd);
	assign n_take = item_acc ? CNT_W'(p_nres) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
			credit_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[FIFO_AW-1:0];
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			fill_q <= fill_q + n_push - CNT_W'(pop);
			credit_q <= credit_q + n_take - CNT_W'(pop);
		end
	end

endmodule

/* tb/asset_transfer_instruction_parser_checker.sv */
// checker for the asset transfer instruction parser: predicts results from accepted bytes and compares
module asset_transfer_instruction_parser_checker import atip_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input item_t item,
	input logic result_valid,
	input logic result_stall,
	input result_t result,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [7:0] cfg_data,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_INSTR = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	cfg_t ranges;
	phase_t phase;
	logic [POS_W-1:0] pos;
	logic hdr_ok;
	logic [7:0] flags;
	logic [12:0] idx_acc;
	logic [ACC_W-1:0] amt_acc;
	logic [2:0] bytes_left;
	logic [2:0] size_code;
	logic matched;
	logic [7:0] in_cnt;

	result_t byte_results[$];
	result_t awaited_results[$];

	task automatic restart_parse();
		pos = '0;
		phase = PH_HEADER;
		hdr_ok = 1'b1;
		flags = '0;
		idx_acc = '0;
		amt_acc = '0;
		bytes_left = '0;
		size_code = '0;
		matched = 1'b0;
		in_cnt = '0;
	endtask

	// mantissa times ten to the low exponent bits, saturating at all ones
	function automatic logic [63:0] scaled_amount(input logic [2:0] code,
			input logic [ACC_W-1:0] acc);
		int ebits;
		logic [3:0] ex;
		logic [127:0] prod;
		if (code >= 3'd1 && code <= 3'd3)
			ebits = 4;
		else if (code == 3'd4 || code == 3'd5)
			ebits = 3;
		else
			ebits = 0;
		ex = 4'(acc & ((56'd1 << ebits) - 56'd1));
		prod = 128'(acc >> ebits);
		repeat (ex) prod = prod * 128'd10;
		return (prod[127:64] != 64'd0) ? '1 : prod[63:0];
	endfunction

	task automatic finish_instr(input logic [63:0] amt, input logic [12:0] tgt);
		result_t r;
		r = '0;
		r.result_kind = KIND_INSTR;
		r.skip_flag = flags[FLAG_SKIP];
		r.range_flag = flags[FLAG_RANGE];
		r.percent_flag = flags[FLAG_PCT];
		r.output_index = idx_acc;
		r.amount = amt;
		r.burn_flag = (idx_acc == BURN_INDEX) && !flags[FLAG_RANGE];
		r.input_index = in_cnt;
		r.header_valid = 1'b1;
		byte_results.push_back(r);
		if (!r.burn_flag && idx_acc == tgt)
			matched = 1'b1;
		if (r.skip_flag)
			in_cnt = in_cnt + 8'd1;
		phase = PH_FLAGS;
	endtask

	task automatic parse_byte(input item_t it);
		logic [7:0] b;
		logic [8:0] len9;
		logic [2:0] code;
		logic in_tr;
		logic in_bu;
		result_t r;
		b = it.script_byte;
		len9 = {1'b0, it.script_length};
		byte_results.delete();
		if (it.first_byte)
			restart_parse();
		case (phase)
			PH_HEADER: begin
				if (pos == POS_MARKER) begin
					if (b != MARKER_OP || it.script_length <= MIN_SCRIPT_LEN)
						hdr_ok = 1'b0;
				end else if (pos == POS_LENGTH) begin
					if (b == 8'd0 || {1'b0, b} + LEN_OVERHEAD > len9)
						hdr_ok = 1'b0;
				end else if (pos == POS_TAG_D) begin
					if (b != TAG_D)
						hdr_ok = 1'b0;
				end else if (pos == POS_TAG_A) begin
					if (b != TAG_A)
						hdr_ok = 1'b0;
				end else if (pos >= POS_TYPE) begin
					in_tr = b >= ranges.transfer_type_low && b <= ranges.transfer_type_high;
					in_bu = b >= ranges.burn_type_low && b <= ranges.burn_type_high;
					if (!in_tr && !in_bu)
						hdr_ok = 1'b0;
					phase = hdr_ok ? PH_FLAGS : PH_DEAD;
				end
			end
			PH_FLAGS: begin
				// no new instruction on the final byte position
				if ({1'b0, pos} + 9'd1 < len9) begin
					flags = b;
					idx_acc = {8'd0, b[4:0]};
					phase = b[FLAG_RANGE] ? PH_INDEX : PH_AMOUNT0;
				end
			end
			PH_INDEX: begin
				idx_acc = {idx_acc[4:0], b};
				phase = PH_AMOUNT0;
			end
			PH_AMOUNT0: begin
				if (flags[FLAG_PCT]) begin
					finish_instr({56'd0, b}, it.target_output);
				end else begin
					code = (b[7:5] == SIZE_CODE_BAD) ? SIZE_CODE_MAX : b[7:5];
					size_code = code;
					amt_acc = (code == SIZE_CODE_MAX) ? {50'd0, b[5:0]} : {51'd0, b[4:0]};
					bytes_left = code;
					if (code == 3'd0)
						finish_instr(scaled_amount(size_code, amt_acc), it.target_output);
					else
						phase = PH_AMOUNTN;
				end
			end
			PH_AMOUNTN: begin
				amt_acc = {amt_acc[ACC_W-9:0], b};
				bytes_left = bytes_left - 3'd1;
				if (bytes_left == 3'd0)
					finish_instr(scaled_amount(size_code, amt_acc), it.target_output);
			end
			default: begin
			end
		endcase
		if (pos != POS_MAX)
			pos = pos + POS_W'(1);
		if (it.last_byte) begin
			r = '0;
			r.result_kind = KIND_VERDICT;
			r.header_valid = hdr_ok && phase != PH_HEADER && phase != PH_DEAD;
			r.asset_sent = r.header_valid && matched;
			byte_results.push_back(r);
			restart_parse();
		end
		if (byte_results.size() > 0) begin
			r = byte_results.pop_back();
			r.last_result = 1'b1;
			byte_results.push_back(r);
		end
		foreach (byte_results[i])
			awaited_results.push_back(byte_results[i]);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (awaited_results.size() == 0) begin
			$error("result transaction with nothing expected: 0x%0h", got);
			fail_count++;
		end else begin
			want = awaited_results.pop_front();
			check_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
			check_field("skip_flag", 64'(want.skip_flag), 64'(got.skip_flag));
			check_field("range_flag", 64'(want.range_flag), 64'(got.range_flag));
			check_field("percent_flag", 64'(want.percent_flag), 64'(got.percent_flag));
			check_field("output_index", 64'(want.output_index), 64'(got.output_index));
			check_field("amount", want.amount, got.amount);
			check_field("burn_flag", 64'(want.burn_flag), 64'(got.burn_flag));
			check_field("input_index", 64'(want.input_index), 64'(got.input_index));
			check_field("asset_sent", 64'(want.asset_sent), 64'(got.asset_sent));
			check_field("header_valid", 64'(want.header_valid), 64'(got.header_valid));
			check_field("last_result", 64'(want.last_result), 64'(got.last_result));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ranges = CFG_RESET;
			restart_parse();
			awaited_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_TRANSFER_LOW: ranges.transfer_type_low = cfg_data;
					REG_TRANSFER_HIGH: ranges.transfer_type_high = cfg_data;
					REG_BURN_LOW: ranges.burn_type_low = cfg_data;
					REG_BURN_HIGH: ranges.burn_type_high = cfg_data;
				endcase
			end
			if (result_valid && !result_stall)
				check_result(result);
			if (item_valid && !item_stall)
				parse_byte(item);
		end
		pending = awaited_results.size();
	end

endmodule

/* tb/asset_transfer_instruction_parser_tb.sv */
// testbench top for the asset transfer instruction parser: script stimulus, flow control and verdict
module asset_transfer_instruction_parser_tb import atip_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	int fail_count;
	int pending;

	cfg_t cur_cfg = CFG_RESET;
	logic [7:0] script_q[$];
	int items_sent = 0;
	int gap_odds = 10;
	int stall_odds = 10;
	bit calm = 1'b0;

	asset_transfer_instruction_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	asset_transfer_instruction_parser_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic offer(input item_t it);
		if (!calm && $urandom_range(0, 99) < gap_odds) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic send_script(input logic [7:0] len, input logic [12:0] tgt);
		item_t it;
		for (int i = 0; i < script_q.size(); i++) begin
			it.script_byte = script_q[i];
			it.script_length = len;
			it.target_output = tgt;
			it.first_byte = (i == 0);
			it.last_byte = (i == script_q.size() - 1);
			offer(it);
		end
	endtask

	function automatic logic [7:0] pick_type();
		logic [7:0] lo;
		logic [7:0] hi;
		if ($urandom_range(0, 1) == 0) begin
			lo = cur_cfg.transfer_type_low;
			hi = cur_cfg.transfer_type_high;
		end else begin
			lo = cur_cfg.burn_type_low;
			hi = cur_cfg.burn_type_high;
		end
		if (lo > hi || $urandom_range(0, 15) == 0)
			return 8'($urandom);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return 8'($urandom_range(hi, lo));
		endcase
	endfunction

	task automatic push_header();
		script_q.delete();
		script_q.push_back(MARKER_OP);
		script_q.push_back(8'd0);	// length byte, set once the script is sized
		script_q.push_back(TAG_D);
		script_q.push_back(TAG_A);
		script_q.push_back(8'($urandom));
		script_q.push_back(pick_type());
	endtask

	task automatic push_instr(input logic [12:0] tgt);
		logic [7:0] fl;
		logic [7:0] lead;
		logic [2:0] extra;
		fl = 8'($urandom);
		case ($urandom_range(0, 3))
			0: fl[4:0] = BURN_INDEX[4:0];
			1: fl[4:0] = fl[FLAG_RANGE] ? tgt[12:8] : tgt[4:0];
			default: begin
			end
		endcase
		script_q.push_back(fl);
		if (fl[FLAG_RANGE])
			script_q.push_back(($urandom_range(0, 2) == 0) ? tgt[7:0] : 8'($urandom));
		if (fl[FLAG_PCT]) begin
			script_q.push_back(8'($urandom));
		end else begin
			lead = 8'($urandom);
			extra = (lead[7:5] == SIZE_CODE_BAD) ? SIZE_CODE_MAX : lead[7:5];
			script_q.push_back(lead);
			repeat (extra) script_q.push_back(8'($urandom));
		end
	endtask

	task automatic noise_script();
		item_t it;
		int n;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			it.script_byte = (i == 0 && $urandom_range(0, 3) == 0) ? MARKER_OP : 8'($urandom);
			it.script_length = 8'($urandom);
			it.target_output = 13'($urandom);
			// occasional restart in the middle of a script
			it.first_byte = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
			it.last_byte = (i == n - 1);
			offer(it);
		end
	endtask

	task automatic random_script();
		logic [12:0] tgt;
		logic [7:0] len;
		int kind;
		int keep;
		tgt = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 40)) : 13'($urandom);
		kind = $urandom_range(0, 99);
		if (kind >= 88) begin
			noise_script();
			return;
		end
		push_header();
		repeat ($urandom_range(0, 6)) push_instr(tgt);
		// stray flags byte at the final position
		if ($urandom_range(0, 4) == 0)
			script_q.push_back(8'($urandom));
		len = 8'(script_q.size());
		if ($urandom_range(0, 5) == 0)
			len = len + 8'($urandom_range(1, 3));
		script_q[1] = len - 8'd2;
		if (kind >= 83) begin
			keep = $urandom_range(1, 5);
			while (script_q.size() > keep) void'(script_q.pop_back());
		end else if (kind >= 75) begin
			case ($urandom_range(0, 6))
				0: script_q[0] = script_q[0] ^ 8'(1 << $urandom_range(0, 7));
				1: script_q[1] = 8'd0;
				2: script_q[1] = len - 8'd1;
				3: script_q[2] = script_q[2] ^ 8'(1 << $urandom_range(0, 7));
				4: script_q[3] = script_q[3] ^ 8'(1 << $urandom_range(0, 7));
				5: len = 8'($urandom_range(0, 6));
				default: script_q[5] = 8'($urandom);
			endcase
		end else if (kind >= 65) begin
			// cut inside the last instruction
			repeat ($urandom_range(1, 3))
				if (script_q.size() > 7)
					void'(script_q.pop_back());
		end
		send_script(len, tgt);
	endtask

	task automatic long_script();
		logic [12:0] tgt;
		tgt = 13'($urandom);
		push_header();
		script_q[1] = 8'd253;
		while (script_q.size() < 270) push_instr(tgt);
		send_script(8'd255, tgt);
	endtask

	task automatic run_random(input int n);
		int goal;
		goal = items_sent + n;
		while (items_sent < goal) random_script();
	endtask

	task automatic put_reg(input cfg_reg_t r, input logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// registers change only once every result is out and the pipeline has drained
	task automatic load_ranges(input cfg_t c);
		item_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		put_reg(REG_TRANSFER_LOW, c.transfer_type_low);
		put_reg(REG_TRANSFER_HIGH, c.transfer_type_high);
		put_reg(REG_BURN_LOW, c.burn_type_low);
		put_reg(REG_BURN_HIGH, c.burn_type_high);
		cfg_valid <= 1'b0;
		cur_cfg = c;
	endtask

	initial begin : receiver
		int cycles;
		cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles == 150) begin
				// long hold-off so the result queue fills and the input stalls
				result_stall <= 1'b1;
				repeat (200) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_odds) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("asset_transfer_instruction_parser_tb failed");
		$finish;
	end

	initial begin : stimulus
		cfg_t c;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// skip+range+percent naming the target, a burn, a saturating amount
		script_q = '{MARKER_OP, 8'd14, TAG_D, TAG_A, 8'h01, cur_cfg.transfer_type_low,
			8'he1, 8'h23, 8'hff, 8'h1f, 8'h1f, 8'h00, 8'h7f, 8'hff, 8'hff, 8'hff};
		send_script(8'd16, 13'h0123);
		// script ends before the type byte
		script_q = '{MARKER_OP, 8'd5, TAG_D};
		send_script(8'd7, 13'd0);
		// burn type, no instructions
		script_q = '{MARKER_OP, 8'd6, TAG_D, TAG_A, 8'h00, cur_cfg.burn_type_high};
		send_script(8'd8, 13'h1fff);

		gap_odds = 15;
		stall_odds = 15;
		run_random(180);

		c.transfer_type_low = 8'd0;
		c.transfer_type_high = 8'd255;
		c.burn_type_low = 8'd255;
		c.burn_type_high = 8'd0;
		load_ranges(c);
		gap_odds = 35;
		stall_odds = 35;
		run_random(100);

		c.transfer_type_low = 8'd255;
		c.transfer_type_high = 8'd255;
		c.burn_type_low = 8'd0;
		c.burn_type_high = 8'd0;
		load_ranges(c);
		gap_odds = 0;
		stall_odds = 0;
		run_random(90);
		long_script();

		c = cfg_t'($urandom);
		load_ranges(c);
		gap_odds = 10;
		stall_odds = 40;
		run_random(90);

		load_ranges(CFG_RESET);
		calm = 1'b1;
		run_random(90);

		item_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("asset_transfer_instruction_parser_tb passed");
		else
			$display("asset_transfer_instruction_parser_tb failed");
		$finish;
	end

endmodule
